// ----- design/assert_macros.svh -----
// assertion macros shared by the stream checkers
// each macro expects clk and rst to be visible where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define STL_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stream check failed");

// consequent must hold in the cycle after the antecedent
`define STL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stream check failed");

// consequent must hold in the cycle after reset is seen
`define STL_ASSERT_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("reset check failed");

`endif

// ----- design/stl_pkg.sv -----
// types, constants and byte-class functions for the script token lexer
// used by stl_scan_core, stl_token_fifo and script_token_lexer
`default_nettype none

package stl_pkg;

  localparam int MAX_SOURCE_BYTES = 65536;
  localparam int POS_CAP_INT = (MAX_SOURCE_BYTES < 65535) ? MAX_SOURCE_BYTES : 65535;
  localparam logic [15:0] POS_CAP = 16'(POS_CAP_INT);
  localparam logic [19:0] LINE_CAP = 20'hFFFFF;
  localparam logic [15:0] FIRST_LINE_RESET = 16'd1;

  localparam int KW_COUNT = 10;
  localparam int KW_MAX_LEN = 6;
  localparam int PREFIX_W = 8 * KW_MAX_LEN;
  localparam int WLEN_W = $clog2(KW_MAX_LEN + 2);
  localparam logic [WLEN_W-1:0] WLEN_LONG = WLEN_W'(KW_MAX_LEN + 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [5:0] {
    TK_END = 6'd0, TK_NUMBER = 6'd1, TK_STRING = 6'd2, TK_IDENT = 6'd3,
    TK_VAR = 6'd4, TK_IF = 6'd5, TK_ELSE = 6'd6, TK_WHILE = 6'd7, TK_FUNC = 6'd8,
    TK_RETURN = 6'd9, TK_TRUE = 6'd10, TK_FALSE = 6'd11, TK_FOR = 6'd12, TK_IN = 6'd13,
    TK_ADD_ASSIGN = 6'd14, TK_INC = 6'd15, TK_PLUS = 6'd16,
    TK_SUB_ASSIGN = 6'd17, TK_DEC = 6'd18, TK_MINUS = 6'd19,
    TK_MUL_ASSIGN = 6'd20, TK_STAR = 6'd21, TK_DIV_ASSIGN = 6'd22, TK_SLASH = 6'd23,
    TK_EQ = 6'd24, TK_ASSIGN = 6'd25, TK_LE = 6'd26, TK_LT = 6'd27,
    TK_GE = 6'd28, TK_GT = 6'd29, TK_LPAREN = 6'd30, TK_RPAREN = 6'd31,
    TK_LBRACE = 6'd32, TK_RBRACE = 6'd33, TK_COMMA = 6'd34, TK_DOT = 6'd35,
    TK_SEMI = 6'd36, TK_AND = 6'd37, TK_NE = 6'd38, TK_NOT = 6'd39, TK_OR = 6'd40,
    TK_LBRACKET = 6'd41, TK_RBRACKET = 6'd42, TK_DOLLAR = 6'd43
  } token_kind_t;

  typedef enum logic [5:0] {
    MODE_IDLE    = 6'b000001,
    MODE_NUM     = 6'b000010,
    MODE_STR     = 6'b000100,
    MODE_WORD    = 6'b001000,
    MODE_COMMENT = 6'b010000,
    MODE_OP      = 6'b100000
  } scan_mode_t;

  typedef enum logic [3:0] {
    OP_PLUS, OP_MINUS, OP_STAR, OP_SLASH, OP_EQUAL,
    OP_LESS, OP_GREATER, OP_AMP, OP_BANG, OP_BAR
  } op_sel_t;

  typedef struct packed {
    logic [7:0]  next_a;
    token_kind_t kind_a;
    logic        has_b;
    logic [7:0]  next_b;
    token_kind_t kind_b;
    logic        has_single;
    token_kind_t single;
  } op_rule_t;

  typedef struct packed {
    logic    hit;
    op_sel_t sel;
  } op_start_t;

  typedef struct packed {
    logic        hit;
    token_kind_t kind;
  } punct_t;

  typedef struct packed {
    token_kind_t kind;
    logic [19:0] line;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } scan_out_t;

  localparam logic [PREFIX_W-1:0] KW_TEXT [KW_COUNT] = '{
    48'h000000726176, 48'h000000006669, 48'h000065736c65, 48'h00656c696877,
    48'h0000636e7566, 48'h6e7275746572, 48'h000065757274, 48'h0065736c6166,
    48'h000000726f66, 48'h000000006e69
  };
  localparam logic [WLEN_W-1:0] KW_LEN [KW_COUNT] = '{
    WLEN_W'(3), WLEN_W'(2), WLEN_W'(4), WLEN_W'(5), WLEN_W'(4),
    WLEN_W'(6), WLEN_W'(4), WLEN_W'(5), WLEN_W'(3), WLEN_W'(2)
  };
  localparam token_kind_t KW_KIND [KW_COUNT] = '{
    TK_VAR, TK_IF, TK_ELSE, TK_WHILE, TK_FUNC,
    TK_RETURN, TK_TRUE, TK_FALSE, TK_FOR, TK_IN
  };

  function automatic logic is_digit(logic [7:0] b);
    return b inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return b inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_word(logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == "_");
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return b inside {[8'd9:8'd13], 8'd32};
  endfunction

  function automatic op_start_t op_start(logic [7:0] b);
    op_start_t r;
    r.hit = 1'b1;
    r.sel = OP_PLUS;
    case (b)
      "+": r.sel = OP_PLUS;
      "-": r.sel = OP_MINUS;
      "*": r.sel = OP_STAR;
      "/": r.sel = OP_SLASH;
      "=": r.sel = OP_EQUAL;
      "<": r.sel = OP_LESS;
      ">": r.sel = OP_GREATER;
      "&": r.sel = OP_AMP;
      "!": r.sel = OP_BANG;
      "|": r.sel = OP_BAR;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic op_rule_t op_rule(op_sel_t sel);
    op_rule_t r;
    r.next_a = "=";
    r.kind_a = TK_EQ;
    r.has_b = 1'b0;
    r.next_b = 8'h00;
    r.kind_b = TK_END;
    r.has_single = 1'b1;
    r.single = TK_ASSIGN;
    case (sel)
      OP_PLUS: begin
        r.kind_a = TK_ADD_ASSIGN; r.has_b = 1'b1; r.next_b = "+";
        r.kind_b = TK_INC; r.single = TK_PLUS;
      end
      OP_MINUS: begin
        r.kind_a = TK_SUB_ASSIGN; r.has_b = 1'b1; r.next_b = "-";
        r.kind_b = TK_DEC; r.single = TK_MINUS;
      end
      OP_STAR: begin
        r.kind_a = TK_MUL_ASSIGN; r.single = TK_STAR;
      end
      OP_SLASH: begin
        r.kind_a = TK_DIV_ASSIGN; r.single = TK_SLASH;
      end
      OP_EQUAL: begin
        r.kind_a = TK_EQ; r.single = TK_ASSIGN;
      end
      OP_LESS: begin
        r.kind_a = TK_LE; r.single = TK_LT;
      end
      OP_GREATER: begin
        r.kind_a = TK_GE; r.single = TK_GT;
      end
      OP_AMP: begin
        r.next_a = "&"; r.kind_a = TK_AND; r.has_single = 1'b0;
      end
      OP_BANG: begin
        r.kind_a = TK_NE; r.single = TK_NOT;
      end
      OP_BAR: begin
        r.next_a = "|"; r.kind_a = TK_OR; r.has_single = 1'b0;
      end
      default: r.has_single = 1'b0;
    endcase
    return r;
  endfunction

  function automatic punct_t punct_kind(logic [7:0] b);
    punct_t r;
    r.hit = 1'b1;
    r.kind = TK_LPAREN;
    case (b)
      "(": r.kind = TK_LPAREN;
      ")": r.kind = TK_RPAREN;
      "{": r.kind = TK_LBRACE;
      "}": r.kind = TK_RBRACE;
      ",": r.kind = TK_COMMA;
      ".": r.kind = TK_DOT;
      ";": r.kind = TK_SEMI;
      "[": r.kind = TK_LBRACKET;
      "]": r.kind = TK_RBRACKET;
      "$": r.kind = TK_DOLLAR;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic token_kind_t word_kind(logic [PREFIX_W-1:0] prefix,
                                            logic [WLEN_W-1:0] wlen);
    token_kind_t k;
    k = TK_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (wlen == KW_LEN[i] && prefix == KW_TEXT[i]) k = KW_KIND[i];
    end
    return k;
  endfunction

  function automatic logic [15:0] text_len(logic [15:0] start, logic [16:0] stop);
    logic [16:0] diff;
    diff = stop - {1'b0, start};
    return (stop > {1'b0, start}) ? diff[15:0] : 16'd0;
  endfunction

endpackage

`default_nettype wire

// ----- design/stl_token_fifo.sv -----
// four-entry token queue between the scanner and the output stream
// takes up to two tokens per beat, gives one; uses stl_pkg
`default_nettype none

module stl_token_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  stl_pkg::scan_out_t wr,
  output logic              room,
  output logic              valid,
  input  logic              pop,
  output stl_pkg::token_t   head
);
  import stl_pkg::*;

  token_t                mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic [1:0]            push_n;
  logic [FIFO_CNT_W-1:0] count_next;

  assign push_n = push ? wr.count : 2'd0;
  assign count_next = count + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
  assign room = count <= FIFO_CNT_W'(FIFO_DEPTH - 2);
  assign valid = count != '0;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push_n);
      if (pop) rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && wr.count != 2'd0) mem[wr_ptr] <= wr.tok0;
    if (push && wr.count == 2'd2) mem[wr_ptr + FIFO_PTR_W'(1)] <= wr.tok1;
  end

endmodule

`default_nettype wire

// ----- design/stl_scan_core.sv -----
// scanner state and one-pass token logic for one source byte or end marker
// holds the first_line register; uses stl_pkg
`default_nettype none

module stl_scan_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         source_byte,
  input  logic               end_marker,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  output stl_pkg::scan_out_t result
);
  import stl_pkg::*;

  scan_mode_t          mode, mode_next;
  op_sel_t             sel, sel_next;
  logic [15:0]         pos, pos_next;
  logic [15:0]         tb, tb_next;
  logic [19:0]         line, line_next;
  logic [PREFIX_W-1:0] prefix, prefix_next;
  logic [WLEN_W-1:0]   wlen, wlen_next;
  logic [15:0]         first_line;

  logic [19:0] line_inc;
  op_rule_t    rule;
  op_start_t   start_hit;
  punct_t      punct;
  logic        rescan;
  logic        e0_v, e1_v;
  token_kind_t e0_kind, e1_kind;
  logic [15:0] e0_start, e1_start;
  logic [16:0] e0_stop, e1_stop;
  token_t      t0, t1;

  assign line_inc = (line < LINE_CAP) ? line + 20'd1 : line;
  assign rule = op_rule(sel);
  assign start_hit = op_start(source_byte);
  assign punct = punct_kind(source_byte);

  always_comb begin
    mode_next = mode;
    sel_next = sel;
    pos_next = pos;
    tb_next = tb;
    line_next = line;
    prefix_next = prefix;
    wlen_next = wlen;
    rescan = 1'b0;
    e0_v = 1'b0;
    e0_kind = TK_END;
    e0_start = tb;
    e0_stop = {1'b0, pos};
    e1_v = 1'b0;
    e1_kind = TK_END;
    e1_start = pos;
    e1_stop = {1'b0, pos};
    if (end_marker) begin
      case (mode)
        MODE_NUM: begin
          e0_v = 1'b1; e0_kind = TK_NUMBER;
        end
        MODE_WORD: begin
          e0_v = 1'b1; e0_kind = word_kind(prefix, wlen);
        end
        MODE_STR: begin
          e0_v = 1'b1; e0_kind = TK_STRING;
        end
        MODE_OP: begin
          e0_v = rule.has_single; e0_kind = rule.single;
          e0_stop = {1'b0, tb} + 17'd1;
        end
        default: ;
      endcase
      e1_v = 1'b1;
      mode_next = MODE_IDLE;
      sel_next = OP_PLUS;
      pos_next = '0;
      tb_next = '0;
      line_next = {4'd0, first_line};
      prefix_next = '0;
      wlen_next = '0;
    end else begin
      pos_next = (pos < POS_CAP) ? pos + 16'd1 : pos;
      case (mode)
        MODE_NUM: begin
          if (!(is_digit(source_byte) || source_byte == ".")) begin
            e0_v = 1'b1; e0_kind = TK_NUMBER;
            mode_next = MODE_IDLE; rescan = 1'b1;
          end
        end
        MODE_WORD: begin
          if (is_word(source_byte)) begin
            if (wlen < WLEN_W'(KW_MAX_LEN)) begin
              for (int i = 0; i < KW_MAX_LEN; i++) begin
                if (wlen == WLEN_W'(i)) prefix_next[8*i +: 8] = source_byte;
              end
              wlen_next = wlen + WLEN_W'(1);
            end else begin
              wlen_next = WLEN_LONG;
            end
          end else begin
            e0_v = 1'b1; e0_kind = word_kind(prefix, wlen);
            mode_next = MODE_IDLE; rescan = 1'b1;
          end
        end
        MODE_STR: begin
          if (source_byte == "\"") begin
            e0_v = 1'b1; e0_kind = TK_STRING;
            mode_next = MODE_IDLE;
          end else if (source_byte == "\n") begin
            line_next = line_inc;
          end
        end
        MODE_COMMENT: begin
          if (source_byte == "\n") begin
            line_next = line_inc;
            mode_next = MODE_IDLE;
          end
        end
        MODE_OP: begin
          mode_next = MODE_IDLE;
          if (sel == OP_SLASH && source_byte == "/") begin
            mode_next = MODE_COMMENT;
          end else if (source_byte == rule.next_a) begin
            e0_v = 1'b1; e0_kind = rule.kind_a;
            e0_stop = {1'b0, pos} + 17'd1;
          end else if (rule.has_b && source_byte == rule.next_b) begin
            e0_v = 1'b1; e0_kind = rule.kind_b;
            e0_stop = {1'b0, pos} + 17'd1;
          end else begin
            e0_v = rule.has_single; e0_kind = rule.single;
            e0_stop = {1'b0, tb} + 17'd1;
            rescan = 1'b1;
          end
        end
        default: begin
          mode_next = MODE_IDLE;
          rescan = 1'b1;
        end
      endcase
      // byte seen from the idle state
      if (rescan) begin
        if (is_space(source_byte)) begin
          if (source_byte == "\n") line_next = line_inc;
        end else if (source_byte == "#") begin
          mode_next = MODE_COMMENT;
        end else if (is_digit(source_byte)) begin
          mode_next = MODE_NUM; tb_next = pos;
        end else if (source_byte == "\"") begin
          mode_next = MODE_STR;
          tb_next = (pos < POS_CAP) ? pos + 16'd1 : pos;
        end else if (is_alpha(source_byte) || source_byte == "_") begin
          mode_next = MODE_WORD; tb_next = pos;
          prefix_next = '0;
          prefix_next[7:0] = source_byte;
          wlen_next = WLEN_W'(1);
        end else if (start_hit.hit) begin
          mode_next = MODE_OP; tb_next = pos;
          sel_next = start_hit.sel;
        end else if (punct.hit) begin
          e1_v = 1'b1; e1_kind = punct.kind;
          e1_start = pos;
          e1_stop = {1'b0, pos} + 17'd1;
        end
      end
    end
  end

  always_comb begin
    t0.kind = e0_kind;
    t0.line = line;
    t0.start = e0_start;
    t0.length = text_len(e0_start, e0_stop);
    t0.last = !e1_v;
    t1.kind = e1_kind;
    t1.line = line;
    t1.start = e1_start;
    t1.length = text_len(e1_start, e1_stop);
    t1.last = 1'b1;
    result.count = {1'b0, e0_v} + {1'b0, e1_v};
    result.tok0 = e0_v ? t0 : t1;
    result.tok1 = t1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      sel <= OP_PLUS;
      pos <= '0;
      tb <= '0;
      line <= {4'd0, FIRST_LINE_RESET};
      prefix <= '0;
      wlen <= '0;
      first_line <= FIRST_LINE_RESET;
    end else begin
      if (step) begin
        mode <= mode_next;
        sel <= sel_next;
        pos <= pos_next;
        tb <= tb_next;
        line <= line_next;
        prefix <= prefix_next;
        wlen <= wlen_next;
      end else if (cfg_wr_en && pos == '0 && mode == MODE_IDLE) begin
        line <= {4'd0, cfg_wr_data};
      end
      if (cfg_wr_en) first_line <= cfg_wr_data;
    end
  end

endmodule

`default_nettype wire

// ----- design/script_token_lexer.sv -----
// Script token lexer: takes one source byte (or an end marker in s_tuser) per beat and gives
// token records. A taken byte is held in an input register and scanned once the token queue has
// room; its tokens are written to the queue and appear on the output behind any tokens queued
// before them. One beat is taken every cycle while the output keeps up; a byte that ends a
// pending token and is itself a one-byte token, or an end marker that flushes a pending token,
// gives two tokens, which leave the single output port one after the other. Input stalls when
// the four-entry token queue cannot take two more tokens. first_line is written while no beat is
// in flight; it also sets the current line count if the current source has not read a byte yet.
// top level; uses stl_pkg, stl_scan_core and stl_token_fifo
`default_nettype none

module script_token_lexer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // source_byte
  input  logic        s_tuser,     // end_marker
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,     // token_kind, token_line, text_start, text_length, zero pad
  output logic        m_tlast,     // last_in_run
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data  // first_line
);
  import stl_pkg::*;

  logic      in_valid;
  logic [7:0] in_byte;
  logic      in_end;
  logic      step;
  logic      room;
  scan_out_t scan;
  token_t    head;

  assign step = in_valid && room;
  assign s_tready = !in_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_end <= s_tuser;
    end
  end

  stl_scan_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .source_byte (in_byte),
    .end_marker  (in_end),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .result      (scan)
  );

  stl_token_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (step),
    .wr    (scan),
    .room  (room),
    .valid (m_tvalid),
    .pop   (m_tvalid && m_tready),
    .head  (head)
  );

  assign m_tdata = {6'd0, head.length, head.start, head.line, head.kind};
  assign m_tlast = head.last;

endmodule

`default_nettype wire

// ----- design/stl_checker.sv -----
// port-level checks on the token output stream of script_token_lexer
// uses assert_macros.svh; bound to the top level below
`default_nettype none
`include "assert_macros.svh"

module stl_checker (
  input wire        clk,
  input wire        rst,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [63:0] m_tdata,
  input wire        m_tlast
);

  `STL_ASSERT_RESET(a_empty_after_reset, !m_tvalid)
  `STL_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
  `STL_ASSERT_ALWAYS(a_end_token, m_tvalid && m_tdata[5:0] == 6'd0, m_tlast && m_tdata[57:42] == 16'd0)
  `STL_ASSERT_ALWAYS(a_kind_and_pad, m_tvalid, m_tdata[63:58] == 6'd0 && m_tdata[5:0] <= 6'd43)

endmodule

bind script_token_lexer stl_checker u_stl_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// ----- bench/tb_script_token_lexer.sv -----
// self-checking bench for script_token_lexer: streams source bytes and end markers,
// predicts every token record and compares each output beat field by field
// depends on stl_pkg (token kinds, token_t, limits) and the script_token_lexer rtl
`timescale 1ns / 100ps

module tb_script_token_lexer;
  import stl_pkg::*;

  localparam int MAX_CYCLES = 200000;
  localparam int DRAIN_QUIET = 8;
  localparam int NO_TOKEN = -1;
  localparam logic [7:0] LF = 8'h0A;

  typedef enum logic [1:0] {ACT_BYTE, ACT_END, ACT_CFG, ACT_DRAIN} stim_act_t;

  typedef struct packed {
    stim_act_t   act;
    logic [7:0]  data;
    logic [15:0] value;
  } stim_t;

  typedef enum logic [2:0] {
    SS_IDLE, SS_NUMBER, SS_STRING, SS_WORD, SS_COMMENT, SS_OPERATOR
  } scan_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;

  script_token_lexer u_dut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // lexer state mirrored by the bench
  scan_state_t lx_state;
  logic [7:0]  lx_op;
  int          lx_pos;
  int          lx_begin;
  logic [19:0] lx_line;
  logic [15:0] lx_first_line;
  logic [47:0] lx_word;
  int          lx_word_len;

  token_t expected_tokens[$];
  stim_t  stim_queue[$];

  int          err_count = 0;
  int          tokens_checked = 0;
  int          bytes_seen = 0;
  int          ends_seen = 0;
  int          cfg_writes = 0;
  int          stim_bytes = 0;
  logic [43:0] kinds_hit = '0;

  string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string lone_chars = "&|/!<";
  string kw_words[10] = '{"var", "if", "else", "while", "func",
                          "return", "true", "false", "for", "in"};
  string op_words[30] = '{"+=", "++", "+", "-=", "--", "-", "*=", "*", "/=", "/",
                          "==", "=", "<=", "<", ">=", ">", "(", ")", "{", "}",
                          ",", ".", ";", "&&", "!=", "!", "||", "[", "]", "$"};

  function automatic bit ch_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit ch_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit ch_word(logic [7:0] b);
    return ch_alpha(b) || ch_digit(b) || b == "_";
  endfunction

  function automatic bit ch_space(logic [7:0] b);
    return (b >= 8'd9 && b <= 8'd13) || b == 8'd32;
  endfunction

  function automatic bit ch_op_first(logic [7:0] b);
    case (b)
      "+", "-", "*", "/", "=", "<", ">", "&", "!", "|": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic int op_pair_kind(logic [7:0] first, logic [7:0] b);
    case (first)
      "+": if (b == "=") return TK_ADD_ASSIGN; else if (b == "+") return TK_INC;
      "-": if (b == "=") return TK_SUB_ASSIGN; else if (b == "-") return TK_DEC;
      "*": if (b == "=") return TK_MUL_ASSIGN;
      "/": if (b == "=") return TK_DIV_ASSIGN;
      "=": if (b == "=") return TK_EQ;
      "<": if (b == "=") return TK_LE;
      ">": if (b == "=") return TK_GE;
      "&": if (b == "&") return TK_AND;
      "!": if (b == "=") return TK_NE;
      "|": if (b == "|") return TK_OR;
      default: ;
    endcase
    return NO_TOKEN;
  endfunction

  function automatic int op_lone_kind(logic [7:0] first);
    case (first)
      "+": return TK_PLUS;
      "-": return TK_MINUS;
      "*": return TK_STAR;
      "/": return TK_SLASH;
      "=": return TK_ASSIGN;
      "<": return TK_LT;
      ">": return TK_GT;
      "!": return TK_NOT;
      default: return NO_TOKEN;
    endcase
  endfunction

  function automatic int punct_of(logic [7:0] b);
    case (b)
      "(": return TK_LPAREN;
      ")": return TK_RPAREN;
      "{": return TK_LBRACE;
      "}": return TK_RBRACE;
      ",": return TK_COMMA;
      ".": return TK_DOT;
      ";": return TK_SEMI;
      "[": return TK_LBRACKET;
      "]": return TK_RBRACKET;
      "$": return TK_DOLLAR;
      default: return NO_TOKEN;
    endcase
  endfunction

  function automatic token_kind_t kw_of(logic [47:0] w, int n);
    if (n > KW_MAX_LEN) return TK_IDENT;
    case (w)
      48'("var"):    return TK_VAR;
      48'("if"):     return TK_IF;
      48'("else"):   return TK_ELSE;
      48'("while"):  return TK_WHILE;
      48'("func"):   return TK_FUNC;
      48'("return"): return TK_RETURN;
      48'("true"):   return TK_TRUE;
      48'("false"):  return TK_FALSE;
      48'("for"):    return TK_FOR;
      48'("in"):     return TK_IN;
      default:       return TK_IDENT;
    endcase
  endfunction

  function automatic int pos_next(int p);
    return (p < POS_CAP_INT) ? p + 1 : POS_CAP_INT;
  endfunction

  task automatic push_token(token_kind_t k, int from, int upto);
    token_t t;
    t.kind = k;
    t.line = lx_line;
    t.start = from[15:0];
    t.length = (upto > from) ? 16'(upto - from) : 16'd0;
    t.last = 1'b0;
    expected_tokens.insert(expected_tokens.size(), t);
  endtask

  task automatic line_up();
    if (lx_line != LINE_CAP) lx_line = lx_line + 20'd1;
  endtask

  task automatic word_push(logic [7:0] b);
    if (lx_word_len < KW_MAX_LEN) begin
      lx_word = {lx_word[39:0], b};
      lx_word_len++;
    end else begin
      lx_word_len = KW_MAX_LEN + 1;
    end
  endtask

  task automatic lex_restart();
    lx_state = SS_IDLE;
    lx_op = 8'd0;
    lx_pos = 0;
    lx_begin = 0;
    lx_line = {4'd0, lx_first_line};
    lx_word = '0;
    lx_word_len = 0;
  endtask

  task automatic lex_config(logic [15:0] v);
    lx_first_line = v;
    if (lx_pos == 0 && lx_state == SS_IDLE) lx_line = {4'd0, v};
  endtask

  // a byte seen with no token open
  task automatic lex_start(logic [7:0] b, int p);
    int k;
    if (ch_space(b)) begin
      if (b == LF) line_up();
    end else if (b == "#") begin
      lx_state = SS_COMMENT;
    end else if (ch_digit(b)) begin
      lx_state = SS_NUMBER;
      lx_begin = p;
    end else if (b == "\"") begin
      lx_state = SS_STRING;
      lx_begin = pos_next(p);
    end else if (ch_alpha(b) || b == "_") begin
      lx_state = SS_WORD;
      lx_begin = p;
      lx_word = '0;
      lx_word_len = 0;
      word_push(b);
    end else if (ch_op_first(b)) begin
      lx_state = SS_OPERATOR;
      lx_begin = p;
      lx_op = b;
    end else begin
      k = punct_of(b);
      if (k != NO_TOKEN) push_token(token_kind_t'(k), p, p + 1);
    end
  endtask

  task automatic lex_byte(logic [7:0] b, int p);
    int k;
    bit rescan;
    rescan = 1'b1;
    case (lx_state)
      SS_NUMBER: begin
        if (ch_digit(b) || b == ".") begin
          rescan = 1'b0;
        end else begin
          push_token(TK_NUMBER, lx_begin, p);
          lx_state = SS_IDLE;
        end
      end
      SS_WORD: begin
        if (ch_word(b)) begin
          word_push(b);
          rescan = 1'b0;
        end else begin
          push_token(kw_of(lx_word, lx_word_len), lx_begin, p);
          lx_state = SS_IDLE;
        end
      end
      SS_STRING: begin
        rescan = 1'b0;
        if (b == "\"") begin
          push_token(TK_STRING, lx_begin, p);
          lx_state = SS_IDLE;
        end else if (b == LF) begin
          line_up();
        end
      end
      SS_COMMENT: begin
        rescan = 1'b0;
        if (b == LF) begin
          line_up();
          lx_state = SS_IDLE;
        end
      end
      SS_OPERATOR: begin
        k = op_pair_kind(lx_op, b);
        if (lx_op == "/" && b == "/") begin
          rescan = 1'b0;
          lx_state = SS_COMMENT;
        end else if (k != NO_TOKEN) begin
          rescan = 1'b0;
          push_token(token_kind_t'(k), lx_begin, p + 1);
          lx_state = SS_IDLE;
        end else begin
          k = op_lone_kind(lx_op);
          if (k != NO_TOKEN) push_token(token_kind_t'(k), lx_begin, lx_begin + 1);
          lx_state = SS_IDLE;
        end
        lx_op = 8'd0;
      end
      default: ;
    endcase
    if (rescan) lex_start(b, p);
  endtask

  task automatic lex_flush();
    int k;
    case (lx_state)
      SS_NUMBER: push_token(TK_NUMBER, lx_begin, lx_pos);
      SS_WORD:   push_token(kw_of(lx_word, lx_word_len), lx_begin, lx_pos);
      SS_STRING: push_token(TK_STRING, lx_begin, lx_pos);
      SS_OPERATOR: begin
        k = op_lone_kind(lx_op);
        if (k != NO_TOKEN) push_token(token_kind_t'(k), lx_begin, lx_begin + 1);
      end
      default: ;
    endcase
    push_token(TK_END, lx_pos, lx_pos);
  endtask

  // one accepted input beat
  task automatic lex_item(logic [7:0] b, logic eom);
    int n_prior;
    token_t t;
    n_prior = expected_tokens.size();
    if (eom) begin
      lex_flush();
      lex_restart();
    end else begin
      lex_byte(b, lx_pos);
      lx_pos = pos_next(lx_pos);
    end
    if (expected_tokens.size() > n_prior) begin
      t = expected_tokens[expected_tokens.size() - 1];
      t.last = 1'b1;
      expected_tokens[expected_tokens.size() - 1] = t;
    end
  endtask

  task automatic put_byte(logic [7:0] b);
    stim_t s;
    s.act = ACT_BYTE;
    s.data = b;
    s.value = 16'd0;
    stim_queue.insert(stim_queue.size(), s);
    stim_bytes++;
  endtask

  task automatic put_end();
    stim_t s;
    s.act = ACT_END;
    s.data = 8'($urandom_range(0, 255));
    s.value = 16'd0;
    stim_queue.insert(stim_queue.size(), s);
  endtask

  task automatic put_drain();
    stim_t s;
    s.act = ACT_DRAIN;
    s.data = 8'd0;
    s.value = 16'd0;
    stim_queue.insert(stim_queue.size(), s);
  endtask

  task automatic put_cfg(logic [15:0] v);
    stim_t s;
    put_drain();
    s.act = ACT_CFG;
    s.data = 8'd0;
    s.value = v;
    stim_queue.insert(stim_queue.size(), s);
  endtask

  task automatic put_text(string txt);
    for (int i = 0; i < txt.len(); i++) put_byte(txt[i]);
  endtask

  // one random piece of script followed by an optional random separator
  task automatic put_fragment();
    logic [7:0] c;
    case ($urandom_range(0, 11))
      0, 1: begin
        put_text(kw_words[$urandom_range(0, 9)]);
        if ($urandom_range(0, 3) == 0) put_byte(word_chars[$urandom_range(0, 62)]);
      end
      2, 3: begin
        put_byte(word_chars[$urandom_range(0, 52)]);
        repeat ($urandom_range(0, 9)) put_byte(word_chars[$urandom_range(0, 62)]);
      end
      4: begin
        c = "0";
        put_byte(c + 8'($urandom_range(0, 9)));
        repeat ($urandom_range(0, 5)) begin
          c = "0";
          c = ($urandom_range(0, 3) == 0) ? 8'(".") : c + 8'($urandom_range(0, 9));
          put_byte(c);
        end
      end
      5: begin
        put_byte("\"");
        repeat ($urandom_range(0, 8)) begin
          c = 8'($urandom_range(0, 255));
          if (c == "\"") c = LF;
          put_byte(c);
        end
        if ($urandom_range(0, 7) != 0) put_byte("\"");
      end
      6, 7, 8: put_text(op_words[$urandom_range(0, 29)]);
      9: begin
        if ($urandom_range(0, 1) == 0) put_byte("#");
        else put_text("//");
        repeat ($urandom_range(0, 8)) put_byte(8'($urandom_range(32, 126)));
        put_byte(LF);
      end
      10: put_byte(8'($urandom_range(0, 255)));
      default: put_byte(lone_chars[$urandom_range(0, 4)]);
    endcase
    case ($urandom_range(0, 5))
      0, 1: ;
      2, 3: put_byte(" ");
      4: put_byte(LF);
      default: put_byte(8'($urandom_range(9, 13)));
    endcase
  endtask

  initial begin
    int phase_start;
    logic [15:0] setting;
    lx_first_line = FIRST_LINE_RESET;
    lex_restart();

    // unknown bytes, lone ampersand, or, line comment, number ended by a paren,
    // keyword, equality, unterminated string flushed by the end marker, empty source
    put_byte(8'h00);
    put_byte(8'hFF);
    put_text("&x||//c\n9.5(return==\"q\n");
    put_end();
    put_end();

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: setting = 16'd0;
        1: setting = 16'hFFFF;
        3: setting = 16'd1;
        default: setting = 16'($urandom_range(0, 65535));
      endcase
      if ($urandom_range(0, 1) == 0) put_end();
      put_cfg(setting);
      phase_start = stim_bytes;
      while (stim_bytes - phase_start < 255) begin
        put_fragment();
        if ($urandom_range(0, 29) == 0) put_end();
        if ($urandom_range(0, 149) == 0) put_drain();
      end
    end
    put_end();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (stim_queue.size() != 0 || s_tvalid || expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("lexed %0d source bytes and %0d end markers across %0d first_line writes",
             bytes_seen, ends_seen, cfg_writes);
    $display("checked %0d token records covering %0d of 44 token kinds",
             tokens_checked, $countones(kinds_hit));
    if (err_count == 0) begin
      $display("script_token_lexer regression: pass");
    end else begin
      $display("script_token_lexer regression: fail");
    end
    $finish;
  end

  // sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;
  int quiet = 0;

  always @(posedge clk) begin
    logic nvalid;
    logic ncfg;
    if (rst) begin
      s_tvalid <= 1'b0;
      cfg_wr_en <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left = 0;
      quiet = 0;
    end else begin
      nvalid = s_tvalid;
      ncfg = 1'b0;
      if (s_tvalid || expected_tokens.size() != 0) quiet = 0;
      else if (quiet < 1000) quiet++;
      if (s_tvalid && s_tready) begin
        lex_item(s_tdata, s_tuser);
        if (s_tuser) ends_seen++;
        else bytes_seen++;
        nvalid = 1'b0;
      end
      if (s_tvalid && !s_tready) begin
        // hold the beat until taken
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (stim_queue.size() != 0) begin
        case (stim_queue[0].act)
          ACT_DRAIN: begin
            if (expected_tokens.size() == 0 && quiet >= DRAIN_QUIET)
              void'(stim_queue.pop_front());
          end
          ACT_CFG: begin
            ncfg = 1'b1;
            cfg_wr_data <= stim_queue[0].value;
            lex_config(stim_queue[0].value);
            cfg_writes++;
            void'(stim_queue.pop_front());
          end
          default: begin
            nvalid = 1'b1;
            s_tdata <= stim_queue[0].data;
            s_tuser <= (stim_queue[0].act == ACT_END);
            void'(stim_queue.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
              burst_left = $urandom_range(1, 24);
              gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
          end
        endcase
      end
      s_tvalid <= nvalid;
      cfg_wr_en <= ncfg;
    end
  end

  task automatic check_field(string what, int want, int got);
    if (want != got) begin
      err_count++;
      $display("%0t: token %0d %s expected %0d got %0d", $time, tokens_checked, what, want, got);
    end
  endtask

  // receiver: the stall pattern rotates through four patterns in turn
  int rx_cycle = 0;

  always @(posedge clk) begin
    token_t want;
    logic nready;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_tokens.size() == 0) begin
          err_count++;
          $display("%0t: expected no token, got beat %h last %b", $time, m_tdata, m_tlast);
        end else begin
          want = expected_tokens.pop_front();
          tokens_checked++;
          kinds_hit[want.kind] = 1'b1;
          check_field("kind", want.kind, m_tdata[5:0]);
          check_field("line", want.line, m_tdata[25:6]);
          check_field("start", want.start, m_tdata[41:26]);
          check_field("length", want.length, m_tdata[57:42]);
          check_field("last", want.last, m_tlast);
        end
      end
      rx_cycle++;
      case ((rx_cycle / 1500) % 4)
        0: nready = 1'b1;
        1: nready = ($urandom_range(0, 3) != 0);
        2: nready = ((rx_cycle % 7) < 3);
        default: nready = ($urandom_range(0, 4) == 0);
      endcase
      m_tready <= nready;
    end
  end

  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= MAX_CYCLES) begin
      $display("%0t: timed out with %0d items and %0d tokens outstanding",
               $time, stim_queue.size(), expected_tokens.size());
      $display("script_token_lexer regression: fail");
      $finish;
    end
  end

endmodule
